>>> rtl/pbde_pkg.sv
// Shared constants, field layout and helper functions of the price bar delta encoder.
`default_nettype none

package pbde_pkg;

    // Field widths of one bar and one delta record
    localparam int PRICE_W     = 32;
    localparam int VOLUME_W    = 48;
    localparam int CHANGE_W    = 16;

    // Packed stream widths (input: four prices and volume, output: base open and five codes)
    localparam int S_DATA_W    = 4 * PRICE_W + VOLUME_W;
    localparam int M_DATA_W    = PRICE_W + 5 * CHANGE_W;

    // Volume code: three significant decimal digits, mantissa shifted left by four
    localparam int MANT_DIGITS = 3;
    localparam int EXP_SHIFT   = 4;
    localparam int MANT_W      = 10;
    localparam int EXP_W       = 5;
    localparam int QBIT_W      = 4;
    localparam int RADIX       = 10;

    // Price differences carry two extra bits for sign and borrow
    typedef logic signed [PRICE_W+1:0] price_diff_t;
    typedef logic [CHANGE_W-1:0]       change_t;

    // Clamp a price difference to the signed 16-bit range
    function automatic change_t sat_s16(input price_diff_t d);
        change_t r;
        if (d < -price_diff_t'(32768)) begin
            r = 16'h8000;
        end else if (d > price_diff_t'(32767)) begin
            r = 16'h7FFF;
        end else begin
            r = d[CHANGE_W-1:0];
        end
        return r;
    endfunction

    // Clamp a price difference to 0..65535
    function automatic change_t sat_u16(input price_diff_t d);
        change_t r;
        if (d < 0) begin
            r = '0;
        end else if (d > price_diff_t'(65535)) begin
            r = 16'hFFFF;
        end else begin
            r = d[CHANGE_W-1:0];
        end
        return r;
    endfunction

    // Upscale factor 10^(3-k) for small deltas (k below three)
    function automatic logic [MANT_W-1:0] small_scale(input logic [1:0] k);
        logic [MANT_W-1:0] r;
        unique case (k)
            2'd0:    r = 10'd1000;
            2'd1:    r = 10'd100;
            2'd2:    r = 10'd10;
            default: r = 10'd1;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/price_bar_delta_encoder.sv
// Top level of the price bar delta encoder: delta capture, volume code sequencer, output register.
//
// Usage:
//   s_ channel carries one daily bar per transaction: tuser is first_of_series, tdata holds
//   open, high, low, close (32 bits each) and volume (48 bits), lowest bits first.
//   m_ channel returns one delta record per bar: tuser is first_bar, tdata holds base_open,
//   open_change, high_change, low_change, close_change and volume_code.
//   Price deltas and the kept close/volume are captured in the accept cycle. The volume
//   code is then built by one shared comparator: a decade search for the smallest 10^k
//   not below the delta (skipped for a zero delta) and, for deltas above 100, a ten-step
//   restoring division by 10^(k-3); a finishing step then forms the code. s_tready is
//   low while this runs and rises again once the record is handed to the output register.
//   The output register holds the record while m_tready is low; a new bar may be accepted
//   and worked on while it waits, and its result waits in turn for the register to free.
//   Reset (aresetn low at a clock edge) clears the previous close and volume to zero,
//   drops any pending record and returns the sequencer to idle.
`default_nettype none

module price_bar_delta_encoder #(
    parameter int PRICE_BITS  = 32,
    parameter int VOLUME_BITS = 48
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // Bits from 0: open[31:0], high, low, close, volume[47:0]
    input  wire logic [pbde_pkg::S_DATA_W-1:0] s_tdata,
    // Bit 0: first_of_series
    input  wire logic                          s_tuser,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // Bits from 0: base_open[31:0], open_change, high_change, low_change, close_change,
    // volume_code (16 bits each)
    output logic [pbde_pkg::M_DATA_W-1:0]      m_tdata,
    // Bit 0: first_bar
    output logic                               m_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready
);
    import pbde_pkg::*;

    // Effective widths: fields are taken in their low PRICE_BITS / VOLUME_BITS bits
    localparam int PW  = (PRICE_BITS < PRICE_W) ? PRICE_BITS : PRICE_W;
    localparam int VW  = (VOLUME_BITS < VOLUME_W) ? VOLUME_BITS : VOLUME_W;
    // Powers of ten up to ten times the largest magnitude
    localparam int PBW = VW + 4;
    localparam logic [PRICE_W-1:0] PRICE_MASK =
        (PW == PRICE_W) ? {PRICE_W{1'b1}} : PRICE_W'((64'd1 << PW) - 64'd1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    state_t              state_reg;

    logic [PW-1:0]       prev_close_reg;
    logic [VW-1:0]       prev_volume_reg;

    // Work record of the bar in progress
    logic                first_reg;
    logic [PRICE_W-1:0]  base_open_reg;
    change_t             open_chg_reg;
    change_t             high_chg_reg;
    change_t             low_chg_reg;
    change_t             close_chg_reg;

    // Volume code sequencer
    logic                neg_reg;
    logic                zero_reg;
    logic [VW-1:0]       mag_reg;
    logic [VW-1:0]       rem_reg;
    logic [PBW-1:0]      pow_reg;
    logic [PBW-1:0]      scale_reg;
    logic [EXP_W-1:0]    k_reg;
    logic [QBIT_W-1:0]   qbit_reg;
    logic [MANT_W-1:0]   quot_reg;

    // Output register
    logic                m_tvalid_reg;
    logic                m_tuser_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;

    logic                s_accept;
    logic                out_free;

    // Field extraction
    logic [PRICE_W-1:0]  open_m;
    logic [PRICE_W-1:0]  high_m;
    logic [PRICE_W-1:0]  low_m;
    logic [PRICE_W-1:0]  close_m;
    logic [VW-1:0]       vol_m;
    logic [PRICE_W-1:0]  prev_close_x;
    logic [VW:0]         vdelta;
    logic [VW:0]         vdelta_neg;

    // Shared unit
    logic [PBW-1:0]      cmp_x;
    logic [PBW-1:0]      cmp_y;
    logic                cmp_ge;
    logic [PBW-1:0]      trial;
    logic [PBW-1:0]      pow_next;
    logic [PBW-1:0]      scale_next;

    // Code assembly
    logic [MANT_W-1:0]   mant;
    logic [16:0]         small_prod;
    change_t             mant_signed;
    change_t             vol_code;

    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

    // Unpack and mask the bar
    assign open_m       = s_tdata[0*PRICE_W +: PRICE_W] & PRICE_MASK;
    assign high_m       = s_tdata[1*PRICE_W +: PRICE_W] & PRICE_MASK;
    assign low_m        = s_tdata[2*PRICE_W +: PRICE_W] & PRICE_MASK;
    assign close_m      = s_tdata[3*PRICE_W +: PRICE_W] & PRICE_MASK;
    assign vol_m        = s_tdata[4*PRICE_W +: VW];
    assign prev_close_x = PRICE_W'(prev_close_reg);

    // Volume delta against the previous bar, or the volume itself on a first bar
    assign vdelta     = {1'b0, vol_m} - (s_tuser ? '0 : {1'b0, prev_volume_reg});
    assign vdelta_neg = '0 - vdelta;

    // Shared comparator: decade search checks 10^k >= |d|, division checks rem >= trial
    assign trial  = scale_reg << qbit_reg;
    assign cmp_x  = (state_reg == ST_DIVIDE) ? PBW'(rem_reg) : pow_reg;
    assign cmp_y  = (state_reg == ST_DIVIDE) ? trial : PBW'(mag_reg);
    assign cmp_ge = (cmp_x >= cmp_y);

    // Times ten as shift and add
    assign pow_next   = (pow_reg << 3) + (pow_reg << 1);
    assign scale_next = (scale_reg << 3) + (scale_reg << 1);

    // Mantissa: quotient for deltas above 100, else the magnitude scaled up
    assign small_prod  = 17'(mag_reg[6:0]) * 17'(small_scale(k_reg[1:0]));
    assign mant        = (k_reg >= EXP_W'(MANT_DIGITS)) ? quot_reg : small_prod[MANT_W-1:0];
    assign mant_signed = neg_reg ? (change_t'(0) - change_t'(mant)) : change_t'(mant);
    assign vol_code    = zero_reg ? '0 :
                         (mant_signed << EXP_SHIFT) + change_t'(k_reg) - change_t'(MANT_DIGITS);

    // Sequencer, kept state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            m_tvalid_reg    <= 1'b0;
            prev_close_reg  <= '0;
            prev_volume_reg <= '0;
        end else begin
            // Release the output transaction unless a new record replaces it
            if (m_tvalid_reg && m_tready && state_reg != ST_FINISH) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        first_reg       <= s_tuser;
                        base_open_reg   <= s_tuser ? open_m : '0;
                        open_chg_reg    <= s_tuser ? '0 :
                                           sat_s16(price_diff_t'(open_m) -
                                                   price_diff_t'(prev_close_x));
                        high_chg_reg    <= sat_u16(price_diff_t'(high_m) - price_diff_t'(open_m));
                        low_chg_reg     <= sat_u16(price_diff_t'(open_m) - price_diff_t'(low_m));
                        close_chg_reg   <= sat_u16(price_diff_t'(close_m) - price_diff_t'(low_m));
                        neg_reg         <= vdelta[VW];
                        zero_reg        <= (vdelta == '0);
                        mag_reg         <= vdelta[VW] ? vdelta_neg[VW-1:0] : vdelta[VW-1:0];
                        pow_reg         <= PBW'(1);
                        scale_reg       <= PBW'(1);
                        k_reg           <= '0;
                        prev_close_reg  <= close_m[PW-1:0];
                        prev_volume_reg <= vol_m;
                        state_reg       <= (vdelta == '0) ? ST_FINISH : ST_SEARCH;
                    end
                end
                ST_SEARCH: begin
                    // Advance 10^k until it reaches the magnitude
                    if (cmp_ge) begin
                        rem_reg   <= mag_reg;
                        quot_reg  <= '0;
                        qbit_reg  <= QBIT_W'(MANT_W - 1);
                        state_reg <= (k_reg >= EXP_W'(MANT_DIGITS)) ? ST_DIVIDE : ST_FINISH;
                    end else begin
                        pow_reg <= pow_next;
                        k_reg   <= k_reg + EXP_W'(1);
                        if (k_reg >= EXP_W'(MANT_DIGITS)) begin
                            scale_reg <= scale_next;
                        end
                    end
                end
                ST_DIVIDE: begin
                    // One quotient bit per cycle, highest first
                    if (cmp_ge) begin
                        rem_reg            <= rem_reg - trial[VW-1:0];
                        quot_reg[qbit_reg] <= 1'b1;
                    end
                    if (qbit_reg == '0) begin
                        state_reg <= ST_FINISH;
                    end else begin
                        qbit_reg <= qbit_reg - QBIT_W'(1);
                    end
                end
                ST_FINISH: begin
                    // Hand the record over once the output register is free
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= first_reg;
                        m_tdata_reg  <= {vol_code, close_chg_reg, low_chg_reg,
                                         high_chg_reg, open_chg_reg, base_open_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Division runs only for deltas above 100
    a_divide_wide: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIVIDE |-> k_reg >= EXP_W'(MANT_DIGITS))
        else $error("division entered for a short volume delta");

    // An accepted bar blocks the input until its record is formed
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_tready)
        else $error("input ready right after an accepted transaction");

    // A new record appears only from the finishing step
    a_valid_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("output valid raised outside the finishing step");

    // Quotient never exceeds three decimal digits plus one
    a_quot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FINISH && k_reg >= EXP_W'(MANT_DIGITS) && !zero_reg
        |-> quot_reg <= MANT_W'(1000) && quot_reg >= MANT_W'(100))
        else $error("volume mantissa out of range");

endmodule

`default_nettype wire
